// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by the top level of the unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/frar_pkg.sv =====
// types and constants of the fraction arithmetic and reduction unit
`timescale 1ns / 1ps

package frar_pkg;

    localparam int STEPS_PER_CYCLE = 8;
    localparam int LANE_COUNT      = 2;
    localparam int LANE_NUM        = 0;
    localparam int LANE_DEN        = 1;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } t_action;

    typedef struct packed {
        t_action            action;
        logic               clear_product;
        logic signed [15:0] left_num;
        logic signed [15:0] left_den;
        logic signed [15:0] right_num;
        logic signed [15:0] right_den;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_num;
        logic signed [31:0] result_den;
        logic signed [31:0] quotient;
        logic               den_zero;
        logic        [31:0] factor_product;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_SIGN,
        ST_PASS,
        ST_QLOAD,
        ST_QUO,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

endpackage

// ===== hw/rtl/frar_div.sv =====
// two-lane trial divider by a small divisor, several quotient bits per cycle while stepped
`timescale 1ns / 1ps

module frar_div #(
    parameter int DATA_WIDTH = 32,
    parameter int K_WIDTH    = 10
) (
    input  logic                                           i_clk,
    input  frar_pkg::t_div_ctl                             i_ctl,
    input  logic [frar_pkg::LANE_COUNT-1:0][DATA_WIDTH-1:0] i_dividend,
    input  logic [K_WIDTH-1:0]                              i_divisor,
    output logic [frar_pkg::LANE_COUNT-1:0][DATA_WIDTH-1:0] o_quotient,
    output logic [frar_pkg::LANE_COUNT-1:0]                 o_rem_zero
);
    import frar_pkg::*;

    localparam int STEP_COUNT = (DATA_WIDTH + STEPS_PER_CYCLE - 1) / STEPS_PER_CYCLE;
    localparam int PAD_WIDTH  = STEP_COUNT * STEPS_PER_CYCLE;

    logic [LANE_COUNT-1:0][PAD_WIDTH-1:0] r_q;
    logic [LANE_COUNT-1:0][K_WIDTH-1:0]   r_r;
    logic [LANE_COUNT-1:0][PAD_WIDTH-1:0] n_q;
    logic [LANE_COUNT-1:0][K_WIDTH-1:0]   n_r;

    always_comb begin : div_steps
        logic [PAD_WIDTH-1:0] q;
        logic [K_WIDTH-1:0]   r;
        logic [K_WIDTH:0]     t;
        for (int l = 0; l < LANE_COUNT; l++) begin
            q = r_q[l];
            r = r_r[l];
            for (int s = 0; s < STEPS_PER_CYCLE; s++) begin
                t = {r, q[PAD_WIDTH-1]};
                q = {q[PAD_WIDTH-2:0], 1'b0};
                if (t >= {1'b0, i_divisor}) begin
                    t    = t - {1'b0, i_divisor};
                    q[0] = 1'b1;
                end
                r = t[K_WIDTH-1:0];
            end
            n_q[l]        = q;
            n_r[l]        = r;
            o_quotient[l] = q[DATA_WIDTH-1:0];
            o_rem_zero[l] = (r == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANE_COUNT; l++) begin
            if (i_ctl.load) begin
                r_q[l] <= PAD_WIDTH'(i_dividend[l]);
                r_r[l] <= '0;
            end else if (i_ctl.step) begin
                r_q[l] <= n_q[l];
                r_r[l] <= n_r[l];
            end
        end
    end

endmodule

// ===== hw/rtl/fraction_arithmetic_reduce_unit.sv =====
// top level of the fraction arithmetic and reduction unit
//
//  channel  direction  payload      handshake
//  in       input      t_in_item    i_in_valid / o_in_stall
//  out      output     t_out_item   o_out_valid / i_out_stall
//
// an item runs through the products, the sign step, PASS_COUNT reduction passes on the
// shared divider, the quotient load, the final quotient and the done state; the passes dominate
// one 16x16 multiplier forms the raw products in ST_MUL0 to ST_MUL2, the final quotient
// takes one bit a cycle; reset is synchronous and sets the factor product to 1
// the input stalls while an item is in work; a finished item waits in the
// output register, and the next item is taken while it waits
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fraction_arithmetic_reduce_unit #(
    parameter int PASS_COUNT = 500,
    parameter int DATA_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  frar_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output frar_pkg::t_out_item o_out_item
);
    import frar_pkg::*;

    localparam int K_MAX       = PASS_COUNT + 2;
    localparam int K_WIDTH     = $clog2(K_MAX + 1);
    localparam int PASS_WIDTH  = $clog2(PASS_COUNT + 1);
    localparam int STEP_COUNT  = (DATA_WIDTH + STEPS_PER_CYCLE - 1) / STEPS_PER_CYCLE;
    localparam int STEP_WIDTH  = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
    localparam int QCNT_WIDTH  = $clog2(DATA_WIDTH);

    t_state                 r_state;
    t_state                 n_state;
    t_in_item               r_in;
    logic signed [32:0]     r_n33;
    logic [DATA_WIDTH-1:0]  r_nw;
    logic [DATA_WIDTH-1:0]  r_dw;
    logic [DATA_WIDTH-1:0]  r_mn;
    logic [DATA_WIDTH-1:0]  r_md;
    logic                   r_n_neg;
    logic                   r_d_neg;
    logic [K_WIDTH-1:0]     r_k;
    logic [PASS_WIDTH-1:0]  r_pass;
    logic [STEP_WIDTH-1:0]  r_step;
    logic [DATA_WIDTH-1:0]  r_qq;
    logic [DATA_WIDTH-1:0]  r_qr;
    logic [QCNT_WIDTH-1:0]  r_qcnt;
    logic [31:0]            r_fprod;
    t_out_item              r_out;
    logic                   r_out_valid;

    logic signed [15:0]     mul_a;
    logic signed [15:0]     mul_b;
    logic signed [31:0]     mul_p;
    t_div_ctl               div_ctl;
    logic [LANE_COUNT-1:0][DATA_WIDTH-1:0] div_a;
    logic [LANE_COUNT-1:0][DATA_WIDTH-1:0] div_q;
    logic [LANE_COUNT-1:0]  div_zero;
    logic                   step_last;
    logic                   pass_last;
    logic                   divisible;
    logic                   out_load;
    logic [DATA_WIDTH-1:0]  mag_n;
    logic [DATA_WIDTH-1:0]  mag_d;
    logic [DATA_WIDTH:0]    q_trial;
    logic                   q_ge;
    logic [DATA_WIDTH:0]    q_diff;
    logic [DATA_WIDTH-1:0]  fin_num;
    logic [DATA_WIDTH-1:0]  fin_den;
    logic [DATA_WIDTH-1:0]  fin_quo;
    logic                   fin_zero;

    // raw product operands
    always_comb begin
        mul_a = r_in.left_num;
        mul_b = r_in.right_den;
        unique case (r_state)
            ST_MUL0: begin
                mul_a = r_in.left_num;
                mul_b = (r_in.action == ACT_MUL) ? r_in.right_num : r_in.right_den;
            end
            ST_MUL1: begin
                mul_a = r_in.right_num;
                mul_b = r_in.left_den;
            end
            ST_MUL2: begin
                mul_a = r_in.left_den;
                mul_b = (r_in.action == ACT_DIV) ? r_in.right_num : r_in.right_den;
            end
            default: begin
                mul_a = r_in.left_num;
                mul_b = r_in.right_den;
            end
        endcase
    end

    assign mul_p = 32'(mul_a) * 32'(mul_b);

    assign mag_n     = r_nw[DATA_WIDTH-1] ? -r_nw : r_nw;
    assign mag_d     = r_dw[DATA_WIDTH-1] ? -r_dw : r_dw;
    assign step_last = (r_step == STEP_WIDTH'(STEP_COUNT - 1));
    assign pass_last = (r_pass == PASS_WIDTH'(PASS_COUNT - 1));
    assign divisible = div_zero[LANE_NUM] && div_zero[LANE_DEN];

    always_comb begin
        if (r_state == ST_PASS && divisible) begin
            div_a = div_q;
        end else if (r_state == ST_PASS) begin
            div_a[LANE_NUM] = r_mn;
            div_a[LANE_DEN] = r_md;
        end else begin
            div_a[LANE_NUM] = mag_n;
            div_a[LANE_DEN] = mag_d;
        end
    end

    frar_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .K_WIDTH    (K_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_ctl      (div_ctl),
        .i_dividend (div_a),
        .i_divisor  (r_k),
        .o_quotient (div_q),
        .o_rem_zero (div_zero)
    );

    // final quotient, one bit a cycle
    assign q_trial = {r_qr, r_qq[DATA_WIDTH-1]};
    assign q_ge    = (q_trial >= {1'b0, r_md});
    assign q_diff  = q_trial - {1'b0, r_md};

    assign fin_zero = (r_md == '0);
    assign fin_num  = r_n_neg ? -r_mn : r_mn;
    assign fin_den  = r_d_neg ? -r_md : r_md;
    assign fin_quo  = fin_zero ? '0 : ((r_n_neg != r_d_neg) ? -r_qq : r_qq);

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    // next state and sequencer outputs
    always_comb begin
        n_state      = r_state;
        div_ctl.load = 1'b0;
        div_ctl.step = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MUL0;
                end
            end
            ST_MUL0: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_SIGN;
            ST_SIGN: begin
                div_ctl.load = 1'b1;
                n_state      = ST_PASS;
            end
            ST_PASS: begin
                div_ctl.step = 1'b1;
                div_ctl.load = step_last;
                if (step_last && pass_last) begin
                    n_state = ST_QLOAD;
                end
            end
            ST_QLOAD: n_state = ST_QUO;
            ST_QUO: begin
                if (r_qcnt == QCNT_WIDTH'(DATA_WIDTH - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_fprod     <= 32'd1;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_IDLE && i_in_valid && i_in_item.clear_product) begin
                r_fprod <= 32'd1;
            end else if (r_state == ST_PASS && step_last && divisible) begin
                r_fprod <= r_fprod * 32'(r_k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_in <= i_in_item;
                end
            end
            ST_MUL0: r_n33 <= 33'(mul_p);
            ST_MUL1: begin
                if (r_in.action == ACT_ADD) begin
                    r_n33 <= r_n33 + 33'(mul_p);
                end else if (r_in.action == ACT_SUB) begin
                    r_n33 <= r_n33 - 33'(mul_p);
                end
            end
            ST_MUL2: begin
                r_dw <= DATA_WIDTH'(mul_p);
                r_nw <= DATA_WIDTH'(r_n33);
            end
            ST_SIGN: begin
                r_n_neg <= r_nw[DATA_WIDTH-1];
                r_d_neg <= r_dw[DATA_WIDTH-1];
                r_mn    <= mag_n;
                r_md    <= mag_d;
                r_k     <= K_WIDTH'(2);
                r_pass  <= '0;
                r_step  <= '0;
            end
            ST_PASS: begin
                if (step_last) begin
                    r_step <= '0;
                    r_pass <= r_pass + 1'b1;
                    if (divisible) begin
                        r_mn <= div_q[LANE_NUM];
                        r_md <= div_q[LANE_DEN];
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
            ST_QLOAD: begin
                r_qq   <= r_mn;
                r_qr   <= '0;
                r_qcnt <= '0;
            end
            ST_QUO: begin
                r_qq   <= {r_qq[DATA_WIDTH-2:0], q_ge};
                r_qr   <= q_ge ? q_diff[DATA_WIDTH-1:0] : q_trial[DATA_WIDTH-1:0];
                r_qcnt <= r_qcnt + 1'b1;
            end
            ST_DONE: begin
                if (out_load) begin
                    r_out.result_num     <= 32'(fin_num);
                    r_out.result_den     <= 32'(fin_den);
                    r_out.quotient       <= 32'(fin_quo);
                    r_out.den_zero       <= fin_zero;
                    r_out.factor_product <= r_fprod;
                end
            end
            default: begin
                r_qcnt <= r_qcnt;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        r_state == ST_MUL0, "accepted item did not start the products")
    `ASSERT_IMPL(a_k_range, i_clk, i_rst_n, r_state == ST_PASS,
        r_k <= K_WIDTH'(K_MAX - 1), "trial divisor out of range")
    `ASSERT_IMPL(a_pass_range, i_clk, i_rst_n, r_state == ST_PASS,
        r_pass < PASS_WIDTH'(PASS_COUNT), "pass count out of range")
    `ASSERT_NEXT(a_fprod_hold, i_clk, i_rst_n, r_state == ST_PASS && !step_last,
        $stable(r_fprod), "factor product changed inside a pass")

endmodule
